### sv/llmt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// llmt_pkg: shared types and constants for line midpoint triangulation
// Widths of the exact intermediate values, payload structs and the
// digit and divider-step helpers used by the pipeline stages.
// ----------------------------------------------------------------------------
package llmt_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int FRAC_BITS   = 16;

	// digit size for splitting wide products into small multipliers
	localparam int DIG  = 32;
	localparam int CW   = COORD_WIDTH;
	localparam int EW   = CW + 1;                  // point sum / difference
	localparam int MW   = 2 * CW + 1;              // one coordinate product
	localparam int PW   = 2 * CW + 3;              // dot product
	localparam int PD   = (PW + DIG - 1) / DIG;    // digits of a dot product
	localparam int GW   = 2 * PW;                  // determinant and numerators
	localparam int NUMW = GW + FRAC_BITS;          // shifted numerator, quotient
	localparam int RW   = GW;                      // divider remainder
	localparam int SW   = NUMW + 1;                // signed scale factor
	localparam int SD   = (SW + DIG - 1) / DIG;    // digits of a scale factor
	localparam int PPW  = DIG + 1 + CW;            // scale digit times direction
	localparam int TW   = SW + CW + 2;             // midpoint sum
	localparam int BIGW = SD * DIG;                // sign-extended digit source

	// dot product slots
	localparam int DOT_A = 0;
	localparam int DOT_B = 1;
	localparam int DOT_C = 2;
	localparam int DOT_D = 3;
	localparam int DOT_E = 4;

	// second-level products
	localparam int NPROD = 6;
	localparam int P_AC  = 0;
	localparam int P_BB  = 1;
	localparam int P_BE  = 2;
	localparam int P_CD  = 3;
	localparam int P_AE  = 4;
	localparam int P_BD  = 5;
	localparam int OP_A [NPROD] = '{DOT_A, DOT_B, DOT_B, DOT_C, DOT_A, DOT_B};
	localparam int OP_B [NPROD] = '{DOT_C, DOT_B, DOT_E, DOT_D, DOT_E, DOT_D};

	typedef struct packed {
		logic signed [CW-1:0] first_point_x;
		logic signed [CW-1:0] first_point_y;
		logic signed [CW-1:0] first_point_z;
		logic signed [CW-1:0] first_dir_x;
		logic signed [CW-1:0] first_dir_y;
		logic signed [CW-1:0] first_dir_z;
		logic signed [CW-1:0] second_point_x;
		logic signed [CW-1:0] second_point_y;
		logic signed [CW-1:0] second_point_z;
		logic signed [CW-1:0] second_dir_x;
		logic signed [CW-1:0] second_dir_y;
		logic signed [CW-1:0] second_dir_z;
	} item_t;

	typedef struct packed {
		logic signed [CW-1:0] mid_x;
		logic signed [CW-1:0] mid_y;
		logic signed [CW-1:0] mid_z;
		logic                 degenerate;
	} result_t;

	// values that ride along until the final sum
	typedef struct packed {
		logic [2:0][EW-1:0] ps;
		logic [2:0][CW-1:0] d1;
		logic [2:0][CW-1:0] d2;
	} side_t;

	typedef logic [4:0][PW-1:0] dots_t;

	typedef struct packed {
		logic [NUMW-1:0] num_s;
		logic [NUMW-1:0] num_t;
		logic [GW-1:0]   g;
		logic            neg_s;
		logic            neg_t;
		logic            deg;
	} quot_in_t;

	typedef struct packed {
		logic [NUMW-1:0] q_s;
		logic [NUMW-1:0] q_t;
		logic            neg_s;
		logic            neg_t;
		logic            deg;
	} quot_t;

	// one signed digit; low digits are unsigned, the top digit carries the sign
	function automatic logic signed [DIG:0] digit(input logic [BIGW-1:0] x,
			input int i, input logic top);
		logic [DIG-1:0] w;
		w = x[i*DIG +: DIG];
		digit = {top & w[DIG-1], w};
	endfunction

	// one restoring division step on {remainder, numerator/quotient}
	function automatic logic [RW+NUMW-1:0] div_step(input logic [RW+NUMW-1:0] rq,
			input logic [GW-1:0] g);
		logic [RW-1:0]   rem;
		logic [NUMW-1:0] nq;
		logic [RW:0]     trial;
		rem   = {rq[RW+NUMW-2:NUMW], rq[NUMW-1]};
		nq    = {rq[NUMW-2:0], 1'b0};
		trial = {1'b0, rem} - {1'b0, g};
		if (!trial[RW]) begin
			rem   = trial[RW-1:0];
			nq[0] = 1'b1;
		end
		div_step = {rem, nq};
	endfunction

endpackage
`default_nettype wire

### sv/line_line_midpoint_triangulation_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// line_line_midpoint_triangulation_top: midpoint of two 3D lines
// Closest-point midpoint of two lines in signed Q16.16, exact integer
// arithmetic, fully pipelined.
// ----------------------------------------------------------------------------
//  channel   signals                            payload   direction
//  item      item_valid, item_ready, item       item_t    in
//  result    result_valid, result_ready, result result_t  out
//
// One transaction enters per cycle and one result leaves per cycle while
// the output register is empty or being drained. The divider, one quotient
// bit per stage over NUMW = 2*(2*CW+3)+FRAC_BITS stages, makes up most of
// the pipeline.
// Reset clears only the valid bits; payload registers hold whatever they had.
// A full output register with result_ready low stalls every stage at once;
// with the output register empty the pipeline keeps flowing.
// ----------------------------------------------------------------------------
module line_line_midpoint_triangulation_top
	import llmt_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	// global advance: move when the output slot is free or being drained
	logic     en;
	logic     dots_vld, gram_vld, div_vld;
	dots_t    dots;
	side_t    dots_side, gram_side, div_side;
	quot_in_t qi;
	quot_t    qo;

	assign en         = !result_valid || result_ready;
	assign item_ready = en;

	// dot products a..e, plus point sum and directions kept for the end
	llmt_dots u_dots (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.item_valid (item_valid),
		.item       (item),
		.vld        (dots_vld),
		.dots       (dots),
		.side       (dots_side)
	);

	// determinant and numerators of s and t
	llmt_gram u_gram (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (dots_vld),
		.dots    (dots),
		.side_in (dots_side),
		.vld     (gram_vld),
		.qi      (qi),
		.side    (gram_side)
	);

	// magnitudes of s and t, truncated toward zero
	llmt_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (gram_vld),
		.qi      (qi),
		.side_in (gram_side),
		.vld     (div_vld),
		.qo      (qo),
		.side    (div_side)
	);

	// midpoint, halving, saturation and the output register
	llmt_mid u_mid (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (div_vld),
		.qo      (qo),
		.side_in (div_side),
		.vld     (result_valid),
		.res     (result)
	);

	// parallel lines always report the origin
	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.degenerate |->
		result.mid_x == '0 && result.mid_y == '0 && result.mid_z == '0)
		else $error("degenerate result with nonzero point");

endmodule
`default_nettype wire

### sv/llmt_dots.sv
`default_nettype none
// ----------------------------------------------------------------------------
// llmt_dots: dot product front end
// Forms P1-P2 and P1+P2, the fifteen coordinate products and the five
// dot products a..e over three register stages.
// ----------------------------------------------------------------------------
module llmt_dots
	import llmt_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  item_valid,
	input  item_t item,
	output logic  vld,
	output dots_t dots,
	output side_t side
);

	logic signed [CW-1:0] p1 [3];
	logic signed [CW-1:0] p2 [3];
	logic signed [CW-1:0] d1 [3];
	logic signed [CW-1:0] d2 [3];

	logic               vld_s1, vld_s2, vld_s3;
	logic [2:0][EW-1:0] r_s1;
	side_t              side_s1, side_s2, side_s3;
	logic [2:0][MW-1:0] pa_s2, pb_s2, pc_s2, pd_s2, pe_s2;
	dots_t              dots_s3;

	logic signed [MW-1:0] mul_a [3];
	logic signed [MW-1:0] mul_b [3];
	logic signed [MW-1:0] mul_c [3];
	logic signed [MW-1:0] mul_d [3];
	logic signed [MW-1:0] mul_e [3];
	logic signed [PW-1:0] sum_n [5];

	always_comb begin
		p1[0] = item.first_point_x;
		p1[1] = item.first_point_y;
		p1[2] = item.first_point_z;
		d1[0] = item.first_dir_x;
		d1[1] = item.first_dir_y;
		d1[2] = item.first_dir_z;
		p2[0] = item.second_point_x;
		p2[1] = item.second_point_y;
		p2[2] = item.second_point_z;
		d2[0] = item.second_dir_x;
		d2[1] = item.second_dir_y;
		d2[2] = item.second_dir_z;
	end

	// stage 1: difference and sum of the points
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				r_s1[k]       <= EW'(p1[k]) - EW'(p2[k]);
				side_s1.ps[k] <= EW'(p1[k]) + EW'(p2[k]);
				side_s1.d1[k] <= d1[k];
				side_s1.d2[k] <= d2[k];
			end
		end
	end

	// stage 2: coordinate products
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			mul_a[k] = $signed(side_s1.d1[k]) * $signed(side_s1.d1[k]);
			mul_b[k] = $signed(side_s1.d1[k]) * $signed(side_s1.d2[k]);
			mul_c[k] = $signed(side_s1.d2[k]) * $signed(side_s1.d2[k]);
			mul_d[k] = $signed(r_s1[k]) * $signed(side_s1.d1[k]);
			mul_e[k] = $signed(r_s1[k]) * $signed(side_s1.d2[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				pa_s2[k] <= mul_a[k];
				pb_s2[k] <= mul_b[k];
				pc_s2[k] <= mul_c[k];
				pd_s2[k] <= mul_d[k];
				pe_s2[k] <= mul_e[k];
			end
			side_s2 <= side_s1;
		end
	end

	// stage 3: dot products
	always_comb begin
		for (int j = 0; j < 5; j++) begin
			sum_n[j] = '0;
		end
		for (int k = 0; k < 3; k++) begin
			sum_n[DOT_A] = sum_n[DOT_A] + PW'($signed(pa_s2[k]));
			sum_n[DOT_B] = sum_n[DOT_B] + PW'($signed(pb_s2[k]));
			sum_n[DOT_C] = sum_n[DOT_C] + PW'($signed(pc_s2[k]));
			sum_n[DOT_D] = sum_n[DOT_D] + PW'($signed(pd_s2[k]));
			sum_n[DOT_E] = sum_n[DOT_E] + PW'($signed(pe_s2[k]));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 5; j++) begin
				dots_s3[j] <= sum_n[j];
			end
			side_s3 <= side_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= item_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	assign vld  = vld_s3;
	assign dots = dots_s3;
	assign side = side_s3;

endmodule
`default_nettype wire

### sv/llmt_gram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// llmt_gram: determinant and scale numerators
// Multiplies dot products digit by digit, sums the partial products, forms
// g = ac - bb, ns = be - cd, nt = ae - bd and prepares the divider operands.
// ----------------------------------------------------------------------------
module llmt_gram
	import llmt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  logic     vld_in,
	input  dots_t    dots,
	input  side_t    side_in,
	output logic     vld,
	output quot_in_t qi,
	output side_t    side
);

	logic signed [2*DIG+1:0] pp_n [NPROD][PD][PD];
	logic signed [2*DIG+1:0] pp_s4 [NPROD][PD][PD];
	logic [GW-1:0]           row_n [NPROD][PD];
	logic [GW-1:0]           row_s5 [NPROD][PD];
	logic [GW-1:0]           prod_n [NPROD];
	logic [GW-1:0]           prod_s6 [NPROD];
	logic [GW-1:0]           g_s7, ns_s7, nt_s7;
	logic [GW-1:0]           abs_s, abs_t;
	quot_in_t                qi_s8;
	side_t                   side_s4, side_s5, side_s6, side_s7, side_s8;
	logic                    vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;

	// stage 4: digit partial products
	always_comb begin
		for (int p = 0; p < NPROD; p++) begin
			for (int i = 0; i < PD; i++) begin
				for (int j = 0; j < PD; j++) begin
					pp_n[p][i][j] =
						digit(BIGW'($signed(dots[OP_A[p]])), i, i == PD - 1) *
						digit(BIGW'($signed(dots[OP_B[p]])), j, j == PD - 1);
				end
			end
		end
	end

	// stage 5: row sums; stage 6: full products (modulo GW, exact in range)
	always_comb begin
		for (int p = 0; p < NPROD; p++) begin
			for (int i = 0; i < PD; i++) begin
				row_n[p][i] = '0;
				for (int j = 0; j < PD; j++) begin
					row_n[p][i] = row_n[p][i] + (GW'(pp_s4[p][i][j]) << (j * DIG));
				end
			end
			prod_n[p] = '0;
			for (int i = 0; i < PD; i++) begin
				prod_n[p] = prod_n[p] + (row_s5[p][i] << (i * DIG));
			end
		end
	end

	assign abs_s = ns_s7[GW-1] ? GW'(-ns_s7) : ns_s7;
	assign abs_t = nt_s7[GW-1] ? GW'(-nt_s7) : nt_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			pp_s4   <= pp_n;
			row_s5  <= row_n;
			prod_s6 <= prod_n;
			g_s7    <= prod_s6[P_AC] - prod_s6[P_BB];
			ns_s7   <= prod_s6[P_BE] - prod_s6[P_CD];
			nt_s7   <= prod_s6[P_AE] - prod_s6[P_BD];
			qi_s8.num_s <= {abs_s, {FRAC_BITS{1'b0}}};
			qi_s8.num_t <= {abs_t, {FRAC_BITS{1'b0}}};
			qi_s8.g     <= g_s7;
			qi_s8.neg_s <= ns_s7[GW-1];
			qi_s8.neg_t <= nt_s7[GW-1];
			qi_s8.deg   <= g_s7[GW-1] | (g_s7 == '0);
			side_s4 <= side_in;
			side_s5 <= side_s4;
			side_s6 <= side_s5;
			side_s7 <= side_s6;
			side_s8 <= side_s7;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_in;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	assign vld  = vld_s8;
	assign qi   = qi_s8;
	assign side = side_s8;

	// the Gram determinant of real lines is never negative
	a_gram_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s7 |-> !g_s7[GW-1])
		else $error("negative determinant");

endmodule
`default_nettype wire

### sv/llmt_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// llmt_div: pipelined restoring divider
// Divides both scale numerators by the determinant, one quotient bit per
// stage, with the remainder and the numerator sharing one shift register.
// ----------------------------------------------------------------------------
module llmt_div
	import llmt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  logic     vld_in,
	input  quot_in_t qi,
	input  side_t    side_in,
	output logic     vld,
	output quot_t    qo,
	output side_t    side
);

	logic                   vld_sn  [NUMW];
	logic [RW+NUMW-1:0]     rqs_sn  [NUMW];
	logic [RW+NUMW-1:0]     rqt_sn  [NUMW];
	logic [GW-1:0]          g_sn    [NUMW];
	logic [2:0]             flg_sn  [NUMW];
	side_t                  side_sn [NUMW];

	for (genvar k = 0; k < NUMW; k++) begin : g_stage
		logic               src_v;
		logic [RW+NUMW-1:0] src_s, src_t;
		logic [GW-1:0]      src_g;
		logic [2:0]         src_f;
		side_t              src_side;

		if (k == 0) begin : g_first
			assign src_v    = vld_in;
			assign src_s    = {{RW{1'b0}}, qi.num_s};
			assign src_t    = {{RW{1'b0}}, qi.num_t};
			assign src_g    = qi.g;
			assign src_f    = {qi.neg_s, qi.neg_t, qi.deg};
			assign src_side = side_in;
		end else begin : g_next
			assign src_v    = vld_sn[k-1];
			assign src_s    = rqs_sn[k-1];
			assign src_t    = rqt_sn[k-1];
			assign src_g    = g_sn[k-1];
			assign src_f    = flg_sn[k-1];
			assign src_side = side_sn[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sn[k] <= 1'b0;
			end else if (en) begin
				vld_sn[k] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rqs_sn[k]  <= div_step(src_s, src_g);
				rqt_sn[k]  <= div_step(src_t, src_g);
				g_sn[k]    <= src_g;
				flg_sn[k]  <= src_f;
				side_sn[k] <= src_side;
			end
		end
	end

	assign vld      = vld_sn[NUMW-1];
	assign qo.q_s   = rqs_sn[NUMW-1][NUMW-1:0];
	assign qo.q_t   = rqt_sn[NUMW-1][NUMW-1:0];
	assign qo.neg_s = flg_sn[NUMW-1][2];
	assign qo.neg_t = flg_sn[NUMW-1][1];
	assign qo.deg   = flg_sn[NUMW-1][0];
	assign side     = side_sn[NUMW-1];

	// a finished division leaves a remainder below the divisor
	a_rem_s: assert property (@(posedge clk) disable iff (!arst_n)
		vld_sn[NUMW-1] && !flg_sn[NUMW-1][0] |->
		rqs_sn[NUMW-1][RW+NUMW-1:NUMW] < g_sn[NUMW-1])
		else $error("s remainder not below divisor");

	a_rem_t: assert property (@(posedge clk) disable iff (!arst_n)
		vld_sn[NUMW-1] && !flg_sn[NUMW-1][0] |->
		rqt_sn[NUMW-1][RW+NUMW-1:NUMW] < g_sn[NUMW-1])
		else $error("t remainder not below divisor");

endmodule
`default_nettype wire

### sv/llmt_mid.sv
`default_nettype none
// ----------------------------------------------------------------------------
// llmt_mid: midpoint back end
// Signs the scale factors, forms s*D1 and t*D2 digit by digit, adds the
// point sum, halves by an arithmetic shift and saturates. Last stage is the
// output register.
// ----------------------------------------------------------------------------
module llmt_mid
	import llmt_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  logic    vld_in,
	input  quot_t   qo,
	input  side_t   side_in,
	output logic    vld,
	output result_t res
);

	logic [SW-1:0]         s_s1, t_s1;
	logic signed [PPW-1:0] pps_n [3][SD];
	logic signed [PPW-1:0] ppt_n [3][SD];
	logic signed [PPW-1:0] pps_s2 [3][SD];
	logic signed [PPW-1:0] ppt_s2 [3][SD];
	logic [TW-1:0]         su_n [3];
	logic [TW-1:0]         tu_n [3];
	logic [TW-1:0]         su_s3 [3];
	logic [TW-1:0]         tu_s3 [3];
	logic [TW-1:0]         tot_s4 [3];
	logic signed [TW-1:0]  sh [3];
	logic [CW-1:0]         sat [3];
	result_t               res_s5;
	side_t                 side_s1, side_s2, side_s3;
	logic                  deg_s1, deg_s2, deg_s3, deg_s4;
	logic                  vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			for (int i = 0; i < SD; i++) begin
				pps_n[c][i] = digit(BIGW'($signed(s_s1)), i, i == SD - 1) *
					$signed(side_s1.d1[c]);
				ppt_n[c][i] = digit(BIGW'($signed(t_s1)), i, i == SD - 1) *
					$signed(side_s1.d2[c]);
			end
			su_n[c] = '0;
			tu_n[c] = '0;
			for (int i = 0; i < SD; i++) begin
				su_n[c] = su_n[c] + (TW'(pps_s2[c][i]) << (i * DIG));
				tu_n[c] = tu_n[c] + (TW'(ppt_s2[c][i]) << (i * DIG));
			end
			// floor halving drops FRAC_BITS+1 bits, then clamp to the coordinate range
			sh[c] = $signed(tot_s4[c]) >>> (FRAC_BITS + 1);
			if (sh[c][TW-1:CW-1] == '0 || sh[c][TW-1:CW-1] == '1) begin
				sat[c] = sh[c][CW-1:0];
			end else if (sh[c][TW-1]) begin
				sat[c] = {1'b1, {(CW-1){1'b0}}};
			end else begin
				sat[c] = {1'b0, {(CW-1){1'b1}}};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_s1    <= qo.neg_s ? SW'(-{1'b0, qo.q_s}) : {1'b0, qo.q_s};
			t_s1    <= qo.neg_t ? SW'(-{1'b0, qo.q_t}) : {1'b0, qo.q_t};
			side_s1 <= side_in;
			deg_s1  <= qo.deg;
			pps_s2  <= pps_n;
			ppt_s2  <= ppt_n;
			side_s2 <= side_s1;
			deg_s2  <= deg_s1;
			su_s3   <= su_n;
			tu_s3   <= tu_n;
			side_s3 <= side_s2;
			deg_s3  <= deg_s2;
			for (int c = 0; c < 3; c++) begin
				tot_s4[c] <= su_s3[c] + tu_s3[c] +
					(TW'($signed(side_s3.ps[c])) << FRAC_BITS);
			end
			deg_s4 <= deg_s3;
			res_s5.mid_x      <= deg_s4 ? '0 : sat[0];
			res_s5.mid_y      <= deg_s4 ? '0 : sat[1];
			res_s5.mid_z      <= deg_s4 ? '0 : sat[2];
			res_s5.degenerate <= deg_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	assign vld = vld_s5;
	assign res = res_s5;

endmodule
`default_nettype wire

### bench/line_line_midpoint_triangulation_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_line_midpoint_triangulation_top_tb: midpoint triangulation bench
// Drives line pairs through the valid/ready item channel, predicts each
// midpoint with wide exact integer math and checks every result in order.
// Runs under several idling phases on both sides.
// ----------------------------------------------------------------------------
module line_line_midpoint_triangulation_top_tb;
	import llmt_pkg::*;

	// wide enough for every exact intermediate: products of 5-digit values
	typedef logic signed [511:0] wide_t;

	// Holds predicted midpoints and checks results against them in order.
	class midpoint_scoreboard;
		result_t pending_mids[$];
		int      fail_count;

		function automatic logic signed [CW-1:0] clamp_coord(input wide_t v);
			wide_t hi;
			wide_t lo;
			hi = (wide_t'(1) <<< (CW - 1)) - 1;
			lo = -(wide_t'(1) <<< (CW - 1));
			if (v > hi) return hi[CW-1:0];
			if (v < lo) return lo[CW-1:0];
			return v[CW-1:0];
		endfunction

		// quotient truncated toward zero, divisor positive
		function automatic wide_t trunc_div(input wide_t n, input wide_t g);
			wide_t q;
			if (n < 0) begin
				q = (-n) / g;
				return -q;
			end
			return n / g;
		endfunction

		// Predict the midpoint of one line pair and queue it.
		function void note_item(input item_t it);
			wide_t p1 [3];
			wide_t d1 [3];
			wide_t p2 [3];
			wide_t d2 [3];
			wide_t r, a, b, c, d, e, g, s, t, tot;
			result_t exp_mid;
			p1[0] = it.first_point_x;  p1[1] = it.first_point_y;  p1[2] = it.first_point_z;
			d1[0] = it.first_dir_x;    d1[1] = it.first_dir_y;    d1[2] = it.first_dir_z;
			p2[0] = it.second_point_x; p2[1] = it.second_point_y; p2[2] = it.second_point_z;
			d2[0] = it.second_dir_x;   d2[1] = it.second_dir_y;   d2[2] = it.second_dir_z;
			a = 0; b = 0; c = 0; d = 0; e = 0;
			for (int i = 0; i < 3; i++) begin
				r = p1[i] - p2[i];
				a += d1[i] * d1[i];
				b += d1[i] * d2[i];
				c += d2[i] * d2[i];
				d += r * d1[i];
				e += r * d2[i];
			end
			g = a * c - b * b;
			exp_mid = '0;
			if (g <= 0) begin
				exp_mid.degenerate = 1'b1;
			end else begin
				s = trunc_div((b * e - c * d) <<< FRAC_BITS, g);
				t = trunc_div((a * e - b * d) <<< FRAC_BITS, g);
				for (int i = 0; i < 3; i++) begin
					tot = ((p1[i] + p2[i]) <<< FRAC_BITS) + s * d1[i] + t * d2[i];
					tot = tot >>> (FRAC_BITS + 1);
					case (i)
						0: exp_mid.mid_x = clamp_coord(tot);
						1: exp_mid.mid_y = clamp_coord(tot);
						default: exp_mid.mid_z = clamp_coord(tot);
					endcase
				end
			end
			pending_mids.push_back(exp_mid);
		endfunction

		function void check_result(input result_t got);
			result_t want;
			if (pending_mids.size() == 0) begin
				$error("unexpected result %h", got);
				fail_count++;
				return;
			end
			want = pending_mids.pop_front();
			if (got.mid_x !== want.mid_x) begin
				$error("mid_x expected %0d actual %0d", want.mid_x, got.mid_x);
				fail_count++;
			end
			if (got.mid_y !== want.mid_y) begin
				$error("mid_y expected %0d actual %0d", want.mid_y, got.mid_y);
				fail_count++;
			end
			if (got.mid_z !== want.mid_z) begin
				$error("mid_z expected %0d actual %0d", want.mid_z, got.mid_z);
				fail_count++;
			end
			if (got.degenerate !== want.degenerate) begin
				$error("degenerate expected %0b actual %0b", want.degenerate,
					got.degenerate);
				fail_count++;
			end
		endfunction
	endclass

	localparam int LATENCY     = 3 + 5 + NUMW + 5;
	localparam int STALL_LIMIT = 20 * LATENCY + 2000;
	localparam int RANDOM_ITEMS = 1250;

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_ready;
	item_t   item;
	logic    result_valid;
	logic    result_ready;
	result_t result;

	int send_idle_pct;   // chance in a hundred that the sender idles
	int recv_stall_pct;  // chance in a hundred that the receiver stalls
	int quiet_cycles = 0;
	midpoint_scoreboard mids;

	line_line_midpoint_triangulation_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Sample both channels at the rising edge; check results, count quiet cycles.
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && item_ready) mids.note_item(item);
			if (result_valid && result_ready) mids.check_result(result);
			if ((item_valid && item_ready) || (result_valid && result_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("line_line_midpoint_triangulation_top_tb: FAIL");
				$finish;
			end
		end
	end

	// Drive result_ready at the falling edge, stalling at the phase's rate.
	always @(negedge clk) begin
		if (!arst_n)
			result_ready <= 1'b0;
		else
			result_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Hold one transaction on the item channel until it is accepted.
	// Valid stays up afterwards; the next call or a drain drops it.
	task automatic send_item(input item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		do @(posedge clk); while (!item_ready);
		@(negedge clk);
	endtask

	function automatic logic signed [CW-1:0] rand_coord();
		case ($urandom_range(5))
			0: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			1: return $signed($urandom_range(0, 511)) - 256;
			2: return $signed($urandom) >>> 8;
			3: return $signed($urandom) >>> $urandom_range(0, 24);
			default: return $signed($urandom);
		endcase
	endfunction

	function automatic item_t rand_item();
		item_t it;
		it.first_point_x  = rand_coord(); it.first_point_y  = rand_coord();
		it.first_point_z  = rand_coord(); it.first_dir_x    = rand_coord();
		it.first_dir_y    = rand_coord(); it.first_dir_z    = rand_coord();
		it.second_point_x = rand_coord(); it.second_point_y = rand_coord();
		it.second_point_z = rand_coord(); it.second_dir_x   = rand_coord();
		it.second_dir_y   = rand_coord(); it.second_dir_z   = rand_coord();
		// parallel or zero directions now and then
		case ($urandom_range(19))
			0: {it.second_dir_x, it.second_dir_y, it.second_dir_z} =
				{it.first_dir_x, it.first_dir_y, it.first_dir_z};
			1: {it.second_dir_x, it.second_dir_y, it.second_dir_z} =
				{-it.first_dir_x, -it.first_dir_y, -it.first_dir_z};
			2: {it.first_dir_x, it.first_dir_y, it.first_dir_z} = '0;
			default: ;
		endcase
		return it;
	endfunction

	function automatic item_t make_item(input int p1x, p1y, p1z, d1x, d1y, d1z,
			p2x, p2y, p2z, d2x, d2y, d2z);
		item_t it;
		it = '{p1x, p1y, p1z, d1x, d1y, d1z, p2x, p2y, p2z, d2x, d2y, d2z};
		return it;
	endfunction

	// Drop valid and wait until every prediction has been checked.
	task automatic drain_results();
		item_valid <= 1'b0;
		while (mids.pending_mids.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		localparam int ONE = 32'h0001_0000;
		localparam int MAXC = 32'h7fffffff;
		localparam int MINC = 32'h80000000;
		mids           = new();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		arst_n         = 1'b0;
		item_valid     = 1'b0;
		item           = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: crossing axes, skew lines, parallel, zero direction, extremes
		send_item(make_item(0, 0, 0, ONE, 0, 0, 0, 0, 0, 0, ONE, 0));
		send_item(make_item(0, 0, ONE, ONE, 0, 0, 0, 0, -ONE, 0, ONE, 0));
		send_item(make_item(ONE, 2 * ONE, 3 * ONE, ONE, ONE, 0, -ONE, 0, 5 * ONE,
			0, ONE, ONE));
		send_item(make_item(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 2 * ONE, 0, 0));
		send_item(make_item(0, 0, 0, ONE, ONE, ONE, 0, ONE, 0, -ONE, -ONE, -ONE));
		send_item(make_item(0, 0, 0, 0, 0, 0, 0, ONE, 0, 0, ONE, 0));
		send_item(make_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_item(make_item(MAXC, MAXC, MAXC, ONE, 0, 0, MAXC, MAXC, MAXC, 0, ONE, 0));
		send_item(make_item(MINC, MINC, MINC, ONE, 0, 0, MINC, MINC, MINC, 0, 0, ONE));
		send_item(make_item(MAXC, MINC, 0, MAXC, MINC, 1, MINC, MAXC, -1, MINC, MAXC, 1));
		send_item(make_item(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MINC, MINC, MINC,
			MINC, MAXC, MINC));
		send_item(make_item(-1, -1, -1, 1, 0, 0, 1, 1, 1, 0, 1, 0));
		send_item(make_item(0, 0, 0, 1, 0, 0, MAXC, MAXC, 0, 0, 1, 1));
		send_item(make_item(0, 0, 0, 1, 1, 0, MAXC, MINC, MAXC, 1, 0, 1));
		send_item(make_item(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, 0, -1));

		// hold the sender until every prediction has been checked
		drain_results();

		// random phases: free run, idle sender, stalling receiver, both, free run again
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
				3: begin send_idle_pct = 15; recv_stall_pct = 15; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			for (int n = 0; n < RANDOM_ITEMS / 5; n++) send_item(rand_item());
		end

		drain_results();
		repeat (LATENCY + 10) @(posedge clk);
		if (mids.fail_count == 0 && mids.pending_mids.size() == 0)
			$display("line_line_midpoint_triangulation_top_tb: PASS");
		else
			$display("line_line_midpoint_triangulation_top_tb: FAIL");
		$finish;
	end

endmodule
